// File: design/drcp_pkg.sv
// drcp_pkg: shared types and constants of the dirty range copy planner.
// No dependencies.
package drcp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ARENA_BYTES    = 2'd0,
    REG_MAX_RANGES     = 2'd1,
    REG_MERGE_GAP      = 2'd2,
    REG_COPY_OVERHEAD  = 2'd3
  } cfg_reg_e;

  localparam int unsigned MAX_RANGES_W = 7;
  // most result items one plan may carry
  localparam int unsigned RESULT_LIMIT = 64;
  // tuser bits of a result item
  localparam int unsigned TUSER_W = 3;

endpackage

// File: design/drcp_ram.sv
// drcp_ram: single write, single read store with registered read data.
// No dependencies.
module drcp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/dirty_range_copy_planner_core.sv
// dirty_range_copy_planner_core: collects dirty ranges and plans copies.
// Depends on drcp_pkg and drcp_ram.
//
// Usage
//   Input items arrive on s_axis: tdata holds dirty_offset then dirty_bytes,
//   tlast marks the final range of a set. Ranges are stored one per cycle
//   while the block is idle. The item with tlast starts planning and the
//   block drops s_axis_tready until the whole plan has been delivered.
//   Result items leave on m_axis: tdata holds copy_offset, copy_bytes and
//   total_bytes; tuser holds full_copy, nothing_to_copy, overflowed; tlast
//   marks the final copy of the plan.
//   Planning is a selection sort through one compare/add unit: each pass
//   reads every stored range once and picks the lowest offset still unused,
//   merging it into the running copy. Each result item is read from the
//   merged run store, loaded into the output register and held there until
//   the receiver takes it; the next item is read only after that.
//   Zero arena or overflow skip the sort and give a single item.
//   A stalled receiver simply holds the output register; nothing is lost.
//   Configuration writes land on the cfg port in one cycle and must only
//   occur while idle.
//   Reset empties the range set, clears the overflow mark and the control
//   and configuration registers; store contents are undefined until written.
module dirty_range_copy_planner_core #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ADDRESS_WIDTH = 48,
  localparam int unsigned InTdataW  = ((2 * ADDRESS_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutTdataW = ((3 * ADDRESS_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write port
  input  logic                     cfg_we_i,
  input  drcp_pkg::cfg_reg_e       cfg_idx_i,
  input  logic [ADDRESS_WIDTH-1:0] cfg_data_i,
  // ranges in
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [InTdataW-1:0]      s_axis_tdata,   // dirty_offset, dirty_bytes
  input  logic                     s_axis_tlast,   // last_range
  // copies out
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OutTdataW-1:0]     m_axis_tdata,   // copy_offset, copy_bytes, total_bytes
  output logic [drcp_pkg::TUSER_W-1:0] m_axis_tuser, // full_copy, nothing_to_copy, overflowed
  output logic                     m_axis_tlast    // last_copy
);
  import drcp_pkg::*;

  localparam int unsigned AW = ADDRESS_WIDTH;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned MW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = AW + MW + 1;   // cost accumulator

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_SCAN, ST_PICK, ST_FLUSH, ST_DECIDE,
    ST_EMIT_RD, ST_EMIT_LD, ST_OUT_WAIT
  } state_e;

  // configuration
  logic [AW-1:0]           arena_q, gap_q, ovh_q;
  logic [MAX_RANGES_W-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= '0;
      max_q   <= '0;
      gap_q   <= '0;
      ovh_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ARENA_BYTES:   arena_q <= cfg_data_i;
        REG_MAX_RANGES:    max_q   <= cfg_data_i[MAX_RANGES_W-1:0];
        REG_MERGE_GAP:     gap_q   <= cfg_data_i;
        REG_COPY_OVERHEAD: ovh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e            state_q, state_d;
  logic [MW-1:0]     cnt_q, cnt_d;       // stored ranges
  logic              ovf_q, ovf_d;
  logic [CAPACITY-1:0] used_q, used_d;   // already consumed by the sort
  logic [MW-1:0]     sc_q, sc_d;         // scan address
  logic              rd_vld_q, rd_vld_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic              best_q, best_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [AW-1:0]     best_off_q, best_off_d, best_end_q, best_end_d;
  logic              run_q, run_d;
  logic [AW-1:0]     cur_start_q, cur_start_d, cur_end_q, cur_end_d;
  logic [MW-1:0]     m_q, m_d;           // merged runs written
  logic [AW-1:0]     total_q, total_d;
  logic [CW-1:0]     cost_q, cost_d;
  logic [MW-1:0]     oi_q, oi_d;         // emit index

  logic                  out_vld_q, out_vld_d, out_last_q, out_last_d;
  logic [AW-1:0]         o_off_q, o_off_d, o_len_q, o_len_d, o_tot_q, o_tot_d;
  logic                  o_full_q, o_full_d, o_none_q, o_none_d;

  // range store
  logic          r_we;
  logic [2*AW-1:0] r_rdata;
  // merged run store
  logic          mg_we;
  logic [2*AW-1:0] mg_wdata, mg_rdata;

  drcp_ram #(.DEPTH(CAPACITY), .WIDTH(2 * AW)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (s_axis_tdata[2*AW-1:0]),
    .raddr_i (sc_q[IW-1:0]),
    .rdata_o (r_rdata)
  );

  drcp_ram #(.DEPTH(CAPACITY), .WIDTH(2 * AW)) u_merge_ram (
    .clk_i   (clk_i),
    .we_i    (mg_we),
    .waddr_i (m_q[IW-1:0]),
    .wdata_i (mg_wdata),
    .raddr_i (oi_q[IW-1:0]),
    .rdata_o (mg_rdata)
  );

  logic          in_acc, out_acc;
  logic [AW-1:0] roff, rlen, rend, run_len;
  logic [AW:0]   rsum;
  logic          elig;
  logic          joins;
  logic [CW-1:0] arena_cost;
  logic [31:0]   m_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = out_vld_q && m_axis_tready;

  // compare/add unit shared by every scan step
  assign roff  = r_rdata[AW-1:0];
  assign rlen  = r_rdata[2*AW-1:AW];
  assign rsum  = {1'b0, roff} + {1'b0, rlen};
  assign rend  = (rsum > {1'b0, arena_q}) ? arena_q : rsum[AW-1:0];
  assign elig  = rd_vld_q && !used_q[rd_idx_q] && (rlen != '0) && (roff < arena_q)
                 && (!best_q || roff < best_off_q);
  assign joins = ({1'b0, best_off_q} <= ({1'b0, cur_end_q} + {1'b0, gap_q}));
  assign run_len    = cur_end_q - cur_start_q;
  assign mg_wdata   = {run_len, cur_start_q};
  assign arena_cost = CW'(arena_q) + CW'(ovh_q);
  assign m_ext      = 32'(m_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    used_d      = used_q;
    sc_d        = sc_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = sc_q[IW-1:0];
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_off_d  = best_off_q;
    best_end_d  = best_end_q;
    run_d       = run_q;
    cur_start_d = cur_start_q;
    cur_end_d   = cur_end_q;
    m_d         = m_q;
    total_d     = total_q;
    cost_d      = cost_q;
    oi_d        = oi_q;
    out_vld_d   = out_vld_q;
    out_last_d  = out_last_q;
    o_off_d     = o_off_q;
    o_len_d     = o_len_q;
    o_tot_d     = o_tot_q;
    o_full_d    = o_full_q;
    o_none_d    = o_none_q;
    r_we        = 1'b0;
    mg_we       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_q < MW'(CAPACITY)) begin
            r_we  = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        used_d  = '0;
        sc_d    = '0;
        best_d  = 1'b0;
        run_d   = 1'b0;
        m_d     = '0;
        total_d = '0;
        cost_d  = '0;
        oi_d    = '0;
        o_off_d = '0;
        o_full_d = 1'b0;
        o_none_d = 1'b0;
        if (arena_q == '0) begin
          // empty plan
          o_len_d    = '0;
          o_tot_d    = '0;
          o_none_d   = 1'b1;
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_OUT_WAIT;
        end else if (ovf_q) begin
          o_len_d    = arena_q;
          o_tot_d    = arena_q;
          o_full_d   = 1'b1;
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_OUT_WAIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc_q < cnt_q) begin
          sc_d     = sc_q + 1'b1;
          rd_vld_d = 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_PICK;
        end
        if (elig) begin
          best_d     = 1'b1;
          best_idx_d = rd_idx_q;
          best_off_d = roff;
          best_end_d = rend;
        end
      end
      ST_PICK: begin
        sc_d   = '0;
        best_d = 1'b0;
        if (!best_q) begin
          state_d = ST_FLUSH;
        end else begin
          used_d[best_idx_q] = 1'b1;
          state_d = ST_SCAN;
          if (!run_q) begin
            run_d       = 1'b1;
            cur_start_d = best_off_q;
            cur_end_d   = best_end_q;
          end else if (joins) begin
            if (best_end_q > cur_end_q) cur_end_d = best_end_q;
          end else begin
            mg_we       = 1'b1;
            m_d         = m_q + 1'b1;
            total_d     = total_q + run_len;
            cost_d      = cost_q + CW'(run_len) + CW'(ovh_q);
            cur_start_d = best_off_q;
            cur_end_d   = best_end_q;
          end
        end
      end
      ST_FLUSH: begin
        if (!run_q) begin
          // nothing survived filtering
          o_off_d    = '0;
          o_len_d    = '0;
          o_tot_d    = '0;
          o_full_d   = 1'b0;
          o_none_d   = 1'b1;
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_OUT_WAIT;
        end else begin
          mg_we   = 1'b1;
          m_d     = m_q + 1'b1;
          total_d = total_q + run_len;
          cost_d  = cost_q + CW'(run_len) + CW'(ovh_q);
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (max_q == '0 || m_ext > 32'(max_q) || m_ext > RESULT_LIMIT
            || cost_q >= arena_cost) begin
          o_off_d    = '0;
          o_len_d    = arena_q;
          o_tot_d    = arena_q;
          o_full_d   = 1'b1;
          o_none_d   = 1'b0;
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          state_d    = ST_OUT_WAIT;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        o_off_d    = mg_rdata[AW-1:0];
        o_len_d    = mg_rdata[2*AW-1:AW];
        o_tot_d    = total_q;
        o_full_d   = 1'b0;
        o_none_d   = 1'b0;
        out_vld_d  = 1'b1;
        out_last_d = (oi_q + 1'b1 == m_q);
        state_d    = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_acc) begin
          out_vld_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            oi_d    = oi_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      used_q    <= '0;
      sc_q      <= '0;
      rd_vld_q  <= 1'b0;
      best_q    <= 1'b0;
      run_q     <= 1'b0;
      m_q       <= '0;
      oi_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      used_q    <= used_d;
      sc_q      <= sc_d;
      rd_vld_q  <= rd_vld_d;
      best_q    <= best_d;
      run_q     <= run_d;
      m_q       <= m_d;
      oi_q      <= oi_d;
      out_vld_q <= out_vld_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_off_q  <= best_off_d;
    best_end_q  <= best_end_d;
    cur_start_q <= cur_start_d;
    cur_end_q   <= cur_end_d;
    total_q     <= total_d;
    cost_q      <= cost_d;
    out_last_q  <= out_last_d;
    o_off_q     <= o_off_d;
    o_len_q     <= o_len_d;
    o_tot_q     <= o_tot_d;
    o_full_q    <= o_full_d;
    o_none_q    <= o_none_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutTdataW'({o_tot_q, o_len_q, o_off_q});
  assign m_axis_tuser  = {ovf_q, o_none_q, o_full_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: design/drcp_checker.sv
// drcp_checker: port-level checks on the copy planner, bound to the top level.
// Depends on dirty_range_copy_planner_core.
module drcp_checker #(
  parameter int unsigned ADDRESS_WIDTH = 48,
  parameter int unsigned OutTdataW     = 144
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic [2:0]           m_axis_tuser,
  input logic                 m_axis_tlast
);

  // no new ranges taken while a plan is being delivered
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");

  // an empty plan is a single zero item
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tlast && !m_axis_tuser[0] && m_axis_tdata == '0))
    else $error("bad empty plan item");

  // a full copy is a single item starting at zero
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tlast && m_axis_tdata[ADDRESS_WIDTH-1:0] == '0))
    else $error("bad full copy item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped under stall");

endmodule

bind dirty_range_copy_planner_core drcp_checker #(
  .ADDRESS_WIDTH (ADDRESS_WIDTH),
  .OutTdataW     (OutTdataW)
) u_drcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/dirty_range_copy_planner_core_test.sv
// Self-checking testbench of dirty_range_copy_planner_core: range sets in, copy plans out.
// Depends on drcp_pkg and the core RTL; a scoreboard class predicts every result item.
module dirty_range_copy_planner_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import drcp_pkg::*;

  localparam int unsigned AW = 48;
  localparam int unsigned CAP = 64;
  localparam logic [AW-1:0] ALL_ONES = {AW{1'b1}};
  localparam int unsigned STALL_LIMIT = 40000;

  typedef struct packed {
    logic [AW-1:0] copy_offset;
    logic [AW-1:0] copy_bytes;
    logic [AW-1:0] total_bytes;
    logic          full_copy;
    logic          nothing_to_copy;
    logic          overflowed;
    logic          last_copy;
  } copy_item_t;

  // Plan predictor and store of expected copy items
  class copy_plan_board;
    logic [AW-1:0] arena, gap, overhead;
    logic [6:0]    max_runs;
    logic [AW-1:0] offs[CAP];
    logic [AW-1:0] lens[CAP];
    int unsigned   count;
    bit            ovf;
    copy_item_t    planned_copies[$];
    int unsigned   errors;

    function void set_reg(cfg_reg_e idx, logic [AW-1:0] val);
      case (idx)
        REG_ARENA_BYTES:   arena = val;
        REG_MAX_RANGES:    max_runs = val[6:0];
        REG_MERGE_GAP:     gap = val;
        REG_COPY_OVERHEAD: overhead = val;
      endcase
    endfunction

    function void push(logic [AW-1:0] o, logic [AW-1:0] b, logic [AW-1:0] t,
                       bit full, bit none, bit last);
      copy_item_t c;
      c.copy_offset = o; c.copy_bytes = b; c.total_bytes = t;
      c.full_copy = full; c.nothing_to_copy = none;
      c.overflowed = ovf; c.last_copy = last;
      planned_copies.insert(planned_copies.size(), c);
    endfunction

    function void plan();
      logic [63:0] so[CAP];
      logic [63:0] sl[CAP];
      logic [63:0] len, pend, rend, total;
      int unsigned n, m, j;
      n = 0;
      total = 0;
      if (arena == 0) begin
        push(0, 0, 0, 0, 1, 1);
        return;
      end
      if (ovf) begin
        push(0, arena, arena, 1, 0, 1);
        return;
      end
      // drop, clip, insertion sort by offset
      for (int i = 0; i < count; i++) begin
        if (lens[i] == 0 || offs[i] >= arena) continue;
        len = 64'(lens[i]);
        if (len > 64'(arena - offs[i])) len = 64'(arena - offs[i]);
        j = n;
        while (j > 0 && so[j-1] > 64'(offs[i])) begin
          so[j] = so[j-1];
          sl[j] = sl[j-1];
          j--;
        end
        so[j] = 64'(offs[i]);
        sl[j] = len;
        n++;
      end
      if (n == 0) begin
        push(0, 0, 0, 0, 1, 1);
        return;
      end
      m = 0;
      for (int i = 1; i < n; i++) begin
        pend = so[m] + sl[m];
        rend = so[i] + sl[i];
        if (so[i] <= pend || so[i] - pend <= 64'(gap)) begin
          sl[m] = (rend > pend ? rend : pend) - so[m];
        end else begin
          m++;
          so[m] = so[i];
          sl[m] = sl[i];
        end
      end
      m++;
      if (max_runs == 0 || m > max_runs || m > RESULT_LIMIT) begin
        push(0, arena, arena, 1, 0, 1);
        return;
      end
      for (int i = 0; i < m; i++) total += sl[i];
      // sums stay well below 2^64 at 48-bit widths
      if (total + 64'(m) * 64'(overhead) >= 64'(arena) + 64'(overhead)) begin
        push(0, arena, arena, 1, 0, 1);
        return;
      end
      for (int i = 0; i < m; i++)
        push(AW'(so[i]), AW'(sl[i]), AW'(total), 0, 0, i + 1 == m);
    endfunction

    function void note_range(logic [AW-1:0] o, logic [AW-1:0] b, bit last);
      if (count < CAP) begin
        offs[count] = o;
        lens[count] = b;
        count++;
      end else begin
        ovf = 1;
      end
      if (last) begin
        plan();
        count = 0;
        ovf = 0;
      end
    endfunction

    function void check_copy(copy_item_t got);
      copy_item_t want;
      if (planned_copies.size() == 0) begin
        $display("%0t: unexpected copy item off=%h bytes=%h", $realtime,
                 got.copy_offset, got.copy_bytes);
        errors++;
        return;
      end
      want = planned_copies.pop_front();
      if (got !== want) begin
        $display("%0t: copy mismatch exp off=%h bytes=%h tot=%h f=%b n=%b o=%b l=%b",
                 $realtime, want.copy_offset, want.copy_bytes, want.total_bytes,
                 want.full_copy, want.nothing_to_copy, want.overflowed, want.last_copy);
        $display("%0t:               got off=%h bytes=%h tot=%h f=%b n=%b o=%b l=%b",
                 $realtime, got.copy_offset, got.copy_bytes, got.total_bytes,
                 got.full_copy, got.nothing_to_copy, got.overflowed, got.last_copy);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  cfg_reg_e         cfg_idx_i = REG_ARENA_BYTES;
  logic [AW-1:0]    cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [95:0]      s_axis_tdata = '0;   // dirty_offset, dirty_bytes
  logic             s_axis_tlast = 1'b0; // last_range
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [143:0]     m_axis_tdata;        // copy_offset, copy_bytes, total_bytes
  logic [TUSER_W-1:0] m_axis_tuser;      // full_copy, nothing_to_copy, overflowed
  logic             m_axis_tlast;        // last_copy

  copy_plan_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_recv = 0;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  dirty_range_copy_planner_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i)
    m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);

  // result monitor
  always @(posedge clk_i) begin
    copy_item_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.copy_offset     = m_axis_tdata[47:0];
      got.copy_bytes      = m_axis_tdata[95:48];
      got.total_bytes     = m_axis_tdata[143:96];
      got.full_copy       = m_axis_tuser[0];
      got.nothing_to_copy = m_axis_tuser[1];
      got.overflowed      = m_axis_tuser[2];
      got.last_copy       = m_axis_tlast;
      board.check_copy(got);
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("dirty_range_copy_planner_core_test: errors");
      $finish;
    end
  end

  function automatic logic [AW-1:0] rand48();
    return AW'({$urandom, $urandom});
  endfunction

  // one range item; valid stays high into the next call if no idle falls
  task automatic send_range(logic [AW-1:0] off, logic [AW-1:0] len, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, off};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_range(off, len, last);
  endtask

  // pause the sender until the plan in flight has been delivered
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.planned_copies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // all four registers, block idle
  task automatic set_regs(logic [AW-1:0] arena, logic [6:0] maxr,
                          logic [AW-1:0] gap, logic [AW-1:0] ovh);
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= (i == 0) ? arena : (i == 1) ? AW'(maxr) : (i == 2) ? gap : ovh;
      board.set_reg(cfg_reg_e'(i), (i == 0) ? arena : (i == 1) ? AW'(maxr) :
                    (i == 2) ? gap : ovh);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // random set: mostly small, ranges clustered in and just past the arena
  task automatic random_set(logic [AW-1:0] arena, int unsigned nmax);
    int unsigned n;
    logic [AW-1:0] span, off, len;
    n = $urandom_range(1, nmax);
    span = (arena == 0 || arena > 48'h1000_0000) ? ALL_ONES : arena + arena / 4;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       begin off = rand48(); len = rand48(); end
        1:       begin
          off = (span == ALL_ONES) ? rand48() : rand48() % (span + 1);
          len = 0;
        end
        default: begin
          off = (span == ALL_ONES) ? rand48() : rand48() % (span + 1);
          len = (span == ALL_ONES) ? rand48() : 1 + rand48() % (arena / 8 + 1);
        end
      endcase
      send_range(off, len, i + 1 == n);
    end
  endtask

  initial begin
    logic [AW-1:0] arena;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: drop, clip, overlap, touch, gap merge
    set_regs(1000, 4, 10, 0);
    send_range(100, 50, 0);
    send_range(50, 60, 0);
    send_range(160, 5, 0);
    send_range(300, 0, 0);
    send_range(2000, 5, 0);
    send_range(1000, 5, 0);
    send_range(990, 100, 1);
    send_range(165, 5, 1);            // single range
    send_range(0, 1000, 1);           // cost reaches full copy
    send_range(10, 1, 0);             // touching pair
    send_range(11, 1, 1);
    set_regs(1000, 2, 0, 0);          // more merged ranges than allowed
    send_range(0, 1, 0);
    send_range(10, 1, 0);
    send_range(20, 1, 1);
    set_regs(0, 64, 0, 0);            // zero arena
    send_range(5, 5, 1);
    set_regs(1000, 0, 0, 0);          // max_ranges zero
    send_range(1, 1, 1);
    set_regs(1000, 64, 0, 0);
    send_range(2000, 3, 1);           // nothing survives
    // store full: one range beyond capacity
    for (int i = 0; i <= CAP; i++) send_range(AW'(i * 10), 1, i == CAP);
    // field extremes
    set_regs(ALL_ONES, 64, ALL_ONES, ALL_ONES);
    send_range(ALL_ONES, ALL_ONES, 0);
    send_range(0, ALL_ONES, 1);
    set_regs(ALL_ONES, 127, 0, 200);
    send_range(0, 1, 0);
    send_range(48'h8000_0000_0000, 1, 1);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 37 : 0;
      recv_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 37 : 0;
      for (int c = 0; c < 2; c++) begin
        case ($urandom_range(3))
          0:       arena = ALL_ONES - $urandom_range(3);
          1:       arena = rand48();
          default: arena = $urandom_range(1, 5000);
        endcase
        set_regs(arena, $urandom_range(0, 64), (c == 0) ? 0 : rand48() % (arena / 16 + 1),
                 ($urandom_range(3) == 0) ? rand48() : $urandom_range(0, 40));
        random_set(arena, 6);
      end
    end

    // long hold-off at the receiver: second set stalls at the input
    set_regs(4000, 64, 3, 1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1;
        repeat (600) @(posedge clk_i);
        hold_recv = 0;
      end
      begin
        random_set(4000, 6);
        random_set(4000, 6);
      end
    join

    drain();
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.planned_copies.size() == 0)
      $display("dirty_range_copy_planner_core_test: clean");
    else
      $display("dirty_range_copy_planner_core_test: errors");
    $finish;
  end
endmodule
